// ===== hdl/sofcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// sofcrc_pkg
// Shared types, constants and CRC helpers for the start-of-frame CRC
// frame unpacker.
// ----------------------------------------------------------------------------
package sofcrc_pkg;

   // frame layout
   localparam int OVERHEAD = 9;
   localparam int STORE_AW = 6;
   localparam int BANK_AW = STORE_AW + 1;
   localparam logic [7:0] START_RESET = 8'hA5;
   localparam logic [6:0] POS_CMD_LO = 7'd5;
   localparam logic [6:0] POS_CMD_HI = 7'd6;
   localparam logic [6:0] POS_PAYLOAD = 7'd7;
   localparam logic [7:0] CRC8_INIT = 8'hFF;
   localparam logic [15:0] CRC16_INIT = 16'hFFFF;
   localparam logic [7:0] CRC8_POLY = 8'h8C;
   localparam logic [15:0] CRC16_POLY = 16'h8408;

   // parser position within a frame
   typedef enum logic [2:0] {
      PS_HUNT,
      PS_LEN_LO,
      PS_LEN_HI,
      PS_SEQ,
      PS_HCRC,
      PS_BODY
   } parse_step_type;

   // one accepted frame waiting for release
   typedef struct packed {
      logic                bank;
      logic [STORE_AW-1:0] len;
      logic [15:0]         cmd;
   } desc_type;

   // payload store write port
   typedef struct packed {
      logic               en;
      logic [BANK_AW-1:0] addr;
      logic [7:0]         data;
   } store_wr_type;

   // bank handed back once its last entry has been read
   typedef struct packed {
      logic en;
      logic bank;
   } bank_rel_type;

   // reflected crc8, one byte
   function automatic logic [7:0] crc8_absorb(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // reflected crc16, one byte
   function automatic logic [15:0] crc16_absorb(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hdl/sofcrc_front.sv =====
// ----------------------------------------------------------------------------
// sofcrc_front
// Byte parser: hunts for the start byte, checks length and header CRC8,
// runs the frame CRC16, writes payload bytes into a free store bank and
// queues a descriptor for every frame whose CRC16 is good.
// ----------------------------------------------------------------------------
module sofcrc_front #(
   parameter int FRAME_LIMIT = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   csr_wr,
   input  logic [7:0]             csr_start_byte,
   output logic                   push_valid,
   output sofcrc_pkg::desc_type   push_desc,
   output sofcrc_pkg::store_wr_type store_wr,
   input  sofcrc_pkg::bank_rel_type bank_rel
);
   import sofcrc_pkg::*;

   localparam logic [15:0] LEN_LIMIT = 16'(FRAME_LIMIT - OVERHEAD);

   parse_step_type state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [7:0]  len_lo_ff, len_lo_in;
   logic [STORE_AW-1:0] len_ff, len_in;
   logic [7:0]  hcrc_ff, hcrc_in;
   logic [15:0] fcrc_ff, fcrc_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [7:0]  start_ff, start_in;
   logic        wr_bank_ff, wr_bank_in;
   logic [1:0]  busy_ff, busy_in;

   logic        acc;
   logic [7:0]  b;
   logic [7:0]  hcrc_nx;
   logic [15:0] fcrc_nx;
   logic [6:0]  cnt_nx;
   logic [15:0] len_full;
   logic        len_ok;
   logic [6:0]  total;
   logic        frame_end;
   logic [6:0]  pay_idx;
   logic        in_payload;

   assign req_stall = busy_ff[wr_bank_ff];
   assign acc       = req_valid && !req_stall;
   assign b         = req_in_byte;

   // per-byte arithmetic
   assign hcrc_nx    = crc8_absorb(hcrc_ff, b);
   assign fcrc_nx    = crc16_absorb(fcrc_ff, b);
   assign cnt_nx     = cnt_ff + 7'd1;
   assign len_full   = {b, len_lo_ff};
   assign len_ok     = len_full < LEN_LIMIT;
   assign total      = 7'(OVERHEAD) + {1'b0, len_ff};
   assign frame_end  = cnt_nx >= total;
   assign pay_idx    = cnt_ff - POS_PAYLOAD;
   assign in_payload = (cnt_ff >= POS_PAYLOAD) && (pay_idx < {1'b0, len_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      if (acc) begin
         unique case (state_ff)
            PS_HUNT:   state_in = (b == start_ff) ? PS_LEN_LO : PS_HUNT;
            PS_LEN_LO: state_in = PS_LEN_HI;
            PS_LEN_HI: state_in = len_ok ? PS_SEQ : PS_HUNT;
            PS_SEQ:    state_in = PS_HCRC;
            PS_HCRC:   state_in = (hcrc_ff == b) ? PS_BODY : PS_HUNT;
            PS_BODY:   state_in = frame_end ? PS_HUNT : PS_BODY;
            default:   state_in = PS_HUNT;
         endcase
      end
   end

   // datapath and outputs
   always_comb begin
      cnt_in     = cnt_ff;
      len_lo_in  = len_lo_ff;
      len_in     = len_ff;
      hcrc_in    = hcrc_ff;
      fcrc_in    = fcrc_ff;
      cmd_in     = cmd_ff;
      wr_bank_in = wr_bank_ff;
      push_valid = 1'b0;
      store_wr.en   = 1'b0;
      store_wr.addr = {wr_bank_ff, pay_idx[STORE_AW-1:0]};
      store_wr.data = b;
      if (acc) begin
         unique case (state_ff)
            PS_HUNT: begin
               if (b == start_ff) begin
                  hcrc_in = crc8_absorb(CRC8_INIT, b);
                  fcrc_in = crc16_absorb(CRC16_INIT, b);
                  cnt_in  = 7'd1;
               end else begin
                  cnt_in = 7'd0;
               end
            end
            PS_LEN_LO: begin
               len_lo_in = b;
               hcrc_in   = hcrc_nx;
               fcrc_in   = fcrc_nx;
               cnt_in    = cnt_nx;
            end
            PS_LEN_HI: begin
               len_in = len_full[STORE_AW-1:0];
               if (len_ok) begin
                  hcrc_in = hcrc_nx;
                  fcrc_in = fcrc_nx;
                  cnt_in  = cnt_nx;
               end else begin
                  hcrc_in = CRC8_INIT;
                  fcrc_in = CRC16_INIT;
                  cnt_in  = 7'd0;
               end
            end
            PS_SEQ: begin
               hcrc_in = hcrc_nx;
               fcrc_in = fcrc_nx;
               cnt_in  = cnt_nx;
            end
            PS_HCRC: begin
               if (hcrc_ff == b) begin
                  fcrc_in = fcrc_nx;
                  cnt_in  = cnt_nx;
               end else begin
                  hcrc_in = CRC8_INIT;
                  fcrc_in = CRC16_INIT;
                  cnt_in  = 7'd0;
               end
            end
            PS_BODY: begin
               if (cnt_ff == POS_CMD_LO) begin
                  cmd_in = {8'h00, b};
               end else if (cnt_ff == POS_CMD_HI) begin
                  cmd_in = {b, cmd_ff[7:0]};
               end else if (in_payload) begin
                  store_wr.en = 1'b1;
               end
               fcrc_in = fcrc_nx;
               cnt_in  = cnt_nx;
               if (frame_end) begin
                  hcrc_in = CRC8_INIT;
                  fcrc_in = CRC16_INIT;
                  cnt_in  = 7'd0;
                  // residue of zero means the received crc matched
                  if (fcrc_nx == 16'h0000) begin
                     push_valid = 1'b1;
                     wr_bank_in = !wr_bank_ff;
                  end
               end
            end
            default: begin
               hcrc_in = CRC8_INIT;
               fcrc_in = CRC16_INIT;
               cnt_in  = 7'd0;
            end
         endcase
      end
   end

   assign push_desc.bank = wr_bank_ff;
   assign push_desc.len  = len_ff;
   assign push_desc.cmd  = cmd_ff;

   // bank ownership: set when a frame is queued, cleared when released
   always_comb begin
      busy_in = busy_ff;
      if (bank_rel.en) begin
         busy_in[bank_rel.bank] = 1'b0;
      end
      if (push_valid) begin
         busy_in[wr_bank_ff] = 1'b1;
      end
   end

   assign start_in = csr_wr ? csr_start_byte : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= PS_HUNT;
         cnt_ff     <= 7'd0;
         hcrc_ff    <= CRC8_INIT;
         fcrc_ff    <= CRC16_INIT;
         cmd_ff     <= 16'h0000;
         len_lo_ff  <= 8'h00;
         len_ff     <= '0;
         start_ff   <= START_RESET;
         wr_bank_ff <= 1'b0;
         busy_ff    <= 2'b00;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         hcrc_ff    <= hcrc_in;
         fcrc_ff    <= fcrc_in;
         cmd_ff     <= cmd_in;
         len_lo_ff  <= len_lo_in;
         len_ff     <= len_in;
         start_ff   <= start_in;
         wr_bank_ff <= wr_bank_in;
         busy_ff    <= busy_in;
      end
   end

endmodule

// ===== hdl/sofcrc_fifo.sv =====
// ----------------------------------------------------------------------------
// sofcrc_fifo
// Two-entry descriptor queue between the parser and the release logic.
// ----------------------------------------------------------------------------
module sofcrc_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sofcrc_pkg::desc_type push_desc,
   input  logic                 pop,
   output logic                 pop_valid,
   output sofcrc_pkg::desc_type pop_desc
);
   import sofcrc_pkg::*;

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign pop_valid = count_ff != 2'd0;
   assign pop_desc  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== hdl/sofcrc_back.sv =====
// ----------------------------------------------------------------------------
// sofcrc_back
// Release side: holds the two-bank payload store and walks one queued frame at
// a time, one payload byte per cycle unless stalled, into a registered result stage.
// ----------------------------------------------------------------------------
module sofcrc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  sofcrc_pkg::store_wr_type store_wr,
   input  logic                     q_valid,
   input  sofcrc_pkg::desc_type     q_desc,
   output logic                     q_pop,
   output sofcrc_pkg::bank_rel_type bank_rel,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [15:0]              rsp_command_id,
   output logic [7:0]               rsp_payload_byte,
   output logic [5:0]               rsp_byte_position,
   output logic [5:0]               rsp_payload_length,
   output logic                     rsp_has_payload,
   output logic                     rsp_last_of_frame
);
   import sofcrc_pkg::*;

   logic [7:0] store_mem [2**BANK_AW];

   // frame being released
   logic                act_valid_ff, act_valid_in;
   logic                act_bank_ff;
   logic [STORE_AW-1:0] act_len_ff;
   logic [15:0]         act_cmd_ff;
   logic [STORE_AW-1:0] act_idx_ff, act_idx_in;

   // read in flight
   logic                rd_pend_ff, rd_pend_in;
   logic [7:0]          rd_data_ff;
   logic [15:0]         pend_cmd_ff;
   logic [STORE_AW-1:0] pend_idx_ff;
   logic [STORE_AW-1:0] pend_len_ff;
   logic                pend_has_ff;
   logic                pend_last_ff;

   // result register
   logic                out_valid_ff, out_valid_in;
   logic [15:0]         out_cmd_ff;
   logic [7:0]          out_data_ff;
   logic [STORE_AW-1:0] out_pos_ff;
   logic [STORE_AW-1:0] out_len_ff;
   logic                out_has_ff;
   logic                out_last_ff;

   logic out_free;
   logic issue;
   logic act_last;
   logic act_has;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign issue    = act_valid_ff && (!rd_pend_ff || out_free);
   assign act_has  = act_len_ff != '0;
   assign act_last = !act_has || ((act_idx_ff + STORE_AW'(1)) == act_len_ff);
   assign q_pop    = q_valid && (!act_valid_ff || (issue && act_last));

   assign bank_rel.en   = issue && act_last;
   assign bank_rel.bank = act_bank_ff;

   // control updates
   always_comb begin
      act_valid_in = act_valid_ff;
      act_idx_in   = act_idx_ff;
      if (issue) begin
         act_idx_in = act_idx_ff + STORE_AW'(1);
         if (act_last) begin
            act_valid_in = 1'b0;
         end
      end
      if (q_pop) begin
         act_valid_in = 1'b1;
         act_idx_in   = '0;
      end
      rd_pend_in   = issue ? 1'b1 : (out_free ? 1'b0 : rd_pend_ff);
      out_valid_in = out_free ? rd_pend_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_valid_ff <= 1'b0;
         act_idx_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         act_valid_ff <= act_valid_in;
         act_idx_ff   <= act_idx_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // descriptor load
   always_ff @(posedge clock) begin
      if (q_pop) begin
         act_bank_ff <= q_desc.bank;
         act_len_ff  <= q_desc.len;
         act_cmd_ff  <= q_desc.cmd;
      end
   end

   // payload store
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr] <= store_wr.data;
      end
      if (issue) begin
         rd_data_ff <= store_mem[{act_bank_ff, act_idx_ff}];
      end
   end

   // side data that travels with the read
   always_ff @(posedge clock) begin
      if (issue) begin
         pend_cmd_ff  <= act_cmd_ff;
         pend_idx_ff  <= act_idx_ff;
         pend_len_ff  <= act_len_ff;
         pend_has_ff  <= act_has;
         pend_last_ff <= act_last;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_cmd_ff  <= pend_cmd_ff;
         out_data_ff <= pend_has_ff ? rd_data_ff : 8'h00;
         out_pos_ff  <= pend_idx_ff;
         out_len_ff  <= pend_len_ff;
         out_has_ff  <= pend_has_ff;
         out_last_ff <= pend_last_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_command_id     = out_cmd_ff;
   assign rsp_payload_byte   = out_data_ff;
   assign rsp_byte_position  = out_pos_ff;
   assign rsp_payload_length = out_len_ff;
   assign rsp_has_payload    = out_has_ff;
   assign rsp_last_of_frame  = out_last_ff;

endmodule

// ===== hdl/sof_crc_frame_unpacker.sv =====
// ----------------------------------------------------------------------------
// sof_crc_frame_unpacker
// Hunts a byte stream for CRC-protected frames and releases the payload of
// every good frame as a run of results tagged with the command id.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per item; an item is taken on a clock
//   edge with req_valid high and req_stall low. The parser absorbs one byte per
//   cycle unless stalled, in that cycle updating the frame CRC16 and, for header bytes ahead of it, the header CRC8.
//   rsp_* gives one result per payload byte (one marked result for an empty
//   payload), held stable while rsp_stall is high.
//   With the release side idle, once the last CRC byte of a good frame is taken,
//   its first result goes through the descriptor queue, the active-frame register,
//   the store read and the result register; after that results flow one per cycle while rsp_stall is low.
//   Payload goes to one of two store banks; req_stall rises only while the
//   parser's next bank still holds a frame not yet fully read out, so
//   bytes keep flowing at one per cycle unless a good frame ends while the
//   frame before it is still being released.
//   csr_* writes the start byte (always ready); write it only while idle.
//   Synchronous reset: parser hunts, start byte is 0xA5, queue and result
//   register are empty. There is no clearing pass.
// ----------------------------------------------------------------------------
module sof_crc_frame_unpacker #(
   parameter int FRAME_LIMIT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_command_id,
   output logic [7:0]  rsp_payload_byte,
   output logic [5:0]  rsp_byte_position,
   output logic [5:0]  rsp_payload_length,
   output logic        rsp_has_payload,
   output logic        rsp_last_of_frame,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_start_byte
);
   import sofcrc_pkg::*;

   logic         push_valid;
   desc_type     push_desc;
   store_wr_type store_wr;
   bank_rel_type bank_rel;
   logic         q_valid;
   desc_type     q_desc;
   logic         q_pop;

   assign csr_ready = 1'b1;

   // parser
   sofcrc_front #(
      .FRAME_LIMIT(FRAME_LIMIT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .csr_wr        (csr_valid && csr_ready),
      .csr_start_byte(csr_start_byte),
      .push_valid    (push_valid),
      .push_desc     (push_desc),
      .store_wr      (store_wr),
      .bank_rel      (bank_rel)
   );

   // frame queue
   sofcrc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_desc(push_desc),
      .pop      (q_pop),
      .pop_valid(q_valid),
      .pop_desc (q_desc)
   );

   // release
   sofcrc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .store_wr          (store_wr),
      .q_valid           (q_valid),
      .q_desc            (q_desc),
      .q_pop             (q_pop),
      .bank_rel          (bank_rel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command_id    (rsp_command_id),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_payload_length(rsp_payload_length),
      .rsp_has_payload   (rsp_has_payload),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
